// ===== rtl/assert_macros.svh =====
// Assertion macros used by the parser RTL (the result queue, cmp_fifo).
// Clock and reset are taken from the clk and rst_n names of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset
`define ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== rtl/cmp_pkg.sv =====
// Types, codes and segment tables of the codestream marker parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cmp_pkg;

    // Input and result items
    typedef struct packed {
        logic [7:0] code_byte;
        logic       first_byte;
    } cmp_in_t;

    typedef struct packed {
        logic [5:0]  field_code;
        logic [31:0] field_value;
        logic [15:0] element_index;
        logic        in_tile;
        logic [3:0]  status;
        logic        last;
    } cmp_out_t;

    // Result handed from the parser to the queue
    typedef struct packed {
        logic     valid;
        cmp_out_t item;
    } cmp_push_t;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Marker bytes: the FF prefix and the second bytes
    localparam logic [7:0] MK_FF  = 8'hFF;
    localparam logic [7:0] MK_SOC = 8'h4F;
    localparam logic [7:0] MK_SIZ = 8'h51;
    localparam logic [7:0] MK_SOT = 8'h90;
    localparam logic [7:0] MK_COD = 8'h52;
    localparam logic [7:0] MK_QCD = 8'h5C;
    localparam logic [7:0] MK_QCC = 8'h5D;
    localparam logic [7:0] MK_COM = 8'h64;
    localparam logic [7:0] MK_EOC = 8'hD9;
    localparam logic [7:0] MK_SOD = 8'h93;
    localparam logic [7:0] MK_COC = 8'h53;

    localparam logic [15:0] WIDE_COMP = 16'd257;

    // Segment kinds
    localparam logic [2:0] SK_SIZ  = 3'd0;
    localparam logic [2:0] SK_COD  = 3'd1;
    localparam logic [2:0] SK_QCD  = 3'd2;
    localparam logic [2:0] SK_QCCM = 3'd3;
    localparam logic [2:0] SK_COM  = 3'd4;
    localparam logic [2:0] SK_SOT  = 3'd5;
    localparam logic [2:0] SK_COC  = 3'd6;
    localparam logic [2:0] SK_QCCT = 3'd7;

    // Field codes with special handling
    localparam logic [5:0] FC_CSIZ = 6'd10;
    localparam logic [5:0] FC_SSIZ = 6'd11;
    localparam logic [5:0] FC_PREC = 6'd24;
    localparam logic [5:0] FC_SPQCD = 6'd27;
    localparam logic [5:0] FC_SPQCC = 6'd31;
    localparam logic [5:0] FC_CMNT = 6'd34;
    localparam logic [5:0] FC_PSOT = 6'd37;
    localparam logic [5:0] FC_DATA = 6'd43;
    localparam logic [5:0] FC_END  = 6'd44;
    localparam logic [5:0] FC_ERR  = 6'd45;
    localparam logic [5:0] FC_SOD  = 6'd46;

    // Status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_NO_SOC   = 4'd1;
    localparam logic [3:0] ST_NO_SIZ   = 4'd2;
    localparam logic [3:0] ST_BAD_LSIZ = 4'd3;
    localparam logic [3:0] ST_MAIN_FF  = 4'd4;
    localparam logic [3:0] ST_MAIN_MK  = 4'd5;
    localparam logic [3:0] ST_TILE_FF  = 4'd6;
    localparam logic [3:0] ST_TILE_MK  = 4'd7;
    localparam logic [3:0] ST_NEXT_FF  = 4'd8;
    localparam logic [3:0] ST_NEXT_MK  = 4'd9;
    localparam logic [3:0] ST_SHORT    = 4'd10;

    localparam int SEG_MAX_FIELDS = 11;

    // Number of fixed fields of a segment kind
    function automatic logic [3:0] seg_count(input logic [2:0] k);
        logic [3:0] n;
        unique case (k)
            SK_SIZ:  n = 4'd11;
            SK_COD:  n = 4'd10;
            SK_QCD:  n = 4'd2;
            SK_QCCM: n = 4'd3;
            SK_COM:  n = 4'd2;
            SK_SOT:  n = 4'd5;
            SK_COC:  n = 4'd8;
            default: n = 4'd3;
        endcase
        return n;
    endfunction

    // Byte size of fixed field i; component numbers take 1 or 2 bytes
    function automatic logic [2:0] seg_size(input logic [2:0] k, input logic [3:0] i,
                                            input logic two);
        logic [2:0] s;
        logic [2:0] comp;
        comp = two ? 3'd2 : 3'd1;
        unique case (k)
            SK_SIZ:  s = (i == 4'd0 || i == 4'd1 || i == 4'd10) ? 3'd2 : 3'd4;
            SK_COD:  s = (i == 4'd0 || i == 4'd3) ? 3'd2 : 3'd1;
            SK_QCD:  s = (i == 4'd0) ? 3'd2 : 3'd1;
            SK_COM:  s = 3'd2;
            SK_SOT:  s = (i == 4'd2) ? 3'd4 : ((i >= 4'd3) ? 3'd1 : 3'd2);
            default: s = (i == 4'd0) ? 3'd2 : ((i == 4'd1) ? comp : 3'd1);
        endcase
        return s;
    endfunction

    // Field code of fixed field i
    function automatic logic [5:0] seg_code(input logic [2:0] k, input logic [3:0] i);
        logic [5:0] c;
        logic [5:0] i6;
        i6 = {2'b00, i};
        unique case (k)
            SK_SIZ:  c = i6;
            SK_COD:  c = 6'd14 + i6;
            SK_QCD:  c = 6'd25 + i6;
            SK_COM:  c = 6'd32 + i6;
            SK_SOT:  c = 6'd35 + i6;
            SK_COC:  c = (i < 4'd3) ? 6'd40 + i6 : 6'd16 + i6;
            default: c = 6'd28 + i6;
        endcase
        return c;
    endfunction

    // Field code of the payload bytes after the fixed fields
    function automatic logic [5:0] seg_tail(input logic [2:0] k);
        logic [5:0] c;
        unique case (k)
            SK_COD, SK_COC:   c = FC_PREC;
            SK_QCD:           c = FC_SPQCD;
            SK_QCCM, SK_QCCT: c = FC_SPQCC;
            SK_COM:           c = FC_CMNT;
            default:          c = FC_SSIZ;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/codestream_marker_parser.sv =====
// Codestream marker parser: one byte per item, zero or one result per byte.
// The result of an accepted byte is written into the result queue and offered from its head entry.
// One byte per cycle while the result queue is not full; the parser state registers update on each accepted byte.
// A four-entry result queue lets input continue while the output stalls.
// Reset (rst_n, asynchronous) returns to expecting SOC with an empty queue.
`timescale 1ns / 1ps

module codestream_marker_parser
    import cmp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  cmp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output cmp_out_t out_data
);

    cmp_push_t push;
    logic      full;
    logic      take;

    assign in_ready = !full;
    assign take = in_valid && in_ready;

    cmp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_item (in_data),
        .push    (push)
    );

    cmp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/cmp_front.sv =====
// Parser front end: accepts codestream bytes, tracks marker and segment state
// and forms at most one result item per byte. Depends on cmp_pkg.
`timescale 1ns / 1ps

module cmp_front
    import cmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  cmp_in_t   in_item,
    output cmp_push_t push
);

    typedef enum logic [3:0] {
        PH_SEG, PH_SOC0, PH_SOC1, PH_SIZ0, PH_SIZ1, PH_MAIN0, PH_MAIN1,
        PH_TILE0, PH_TILE1, PH_DATA, PH_NEXT0, PH_NEXT1, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, ph;
    logic [2:0]  kind_reg, kind_next, kd;
    logic [15:0] pos_reg, pos_next, pos;
    logic [15:0] len_reg, len_next, len;
    logic [31:0] vs_reg, vs_next, vs;
    logic [15:0] cc_reg, cc_next, cc;
    logic [31:0] tbs_reg, tbs_next, tbs;
    logic [31:0] tpl_reg, tpl_next, tpl;
    logic [31:0] dbl_reg, dbl_next, dbl;

    logic [7:0]  b;
    logic        two, seg_tile;
    logic [3:0]  cnt;
    logic [6:0]  fixed, fstart;
    logic [2:0]  sz;
    logic        found, f_first, f_last;
    logic [3:0]  fidx;
    logic [5:0]  fcode;
    logic [31:0] v;
    logic [15:0] t;
    logic [32:0] prod;
    logic [15:0] comp;
    logic [15:0] rem;
    logic [17:0] lsiz_exp;
    logic [16:0] pos1;
    logic        err;
    logic [3:0]  err_st;
    logic [31:0] err_val;
    logic        err_tile;
    cmp_out_t    res;
    logic        res_v;

    assign b = in_item.code_byte;

    // Restart on first_byte: parse from reset state
    always_comb
    begin
        if (in_item.first_byte)
        begin
            ph = PH_SOC0; kd = SK_SIZ; pos = '0; len = '0; vs = '0; cc = '0;
            tbs = '0; tpl = '0; dbl = '0;
        end
        else
        begin
            ph = phase_reg; kd = kind_reg; pos = pos_reg; len = len_reg; vs = vs_reg;
            cc = cc_reg; tbs = tbs_reg; tpl = tpl_reg; dbl = dbl_reg;
        end
    end

    // Field lookup within the current segment
    always_comb
    begin
        two = (cc >= WIDE_COMP);
        cnt = seg_count(kd);
        fixed = '0; fstart = '0; found = 1'b0; f_first = 1'b0; f_last = 1'b0;
        fidx = '0; sz = '0;
        for (int i = 0; i < SEG_MAX_FIELDS; i++)
        begin
            if (4'(i) < cnt)
            begin
                sz = seg_size(kd, 4'(i), two);
                if (!found && pos >= {9'd0, fixed} && pos < {9'd0, fixed + 7'(sz)})
                begin
                    found = 1'b1;
                    fstart = fixed;
                    fidx = 4'(i);
                end
                fixed = fixed + 7'(sz);
            end
        end
        sz = seg_size(kd, fidx, two);
        f_first = found && (pos == {9'd0, fstart});
        f_last = found && (pos == {9'd0, fstart + 7'(sz) - 7'd1});
    end

    // Next state and result
    always_comb
    begin
        phase_next = ph; kind_next = kd; pos_next = pos; len_next = len; vs_next = vs;
        cc_next = cc; tpl_next = tpl; dbl_next = dbl; tbs_next = tbs;
        err = 1'b0; err_st = ST_OK; err_val = '0; err_tile = 1'b0;
        res = '0; res_v = 1'b0;
        seg_tile = (kd >= SK_SOT);
        fcode = seg_code(kd, fidx);
        v = f_first ? {24'd0, b} : {vs[23:0], b};
        t = pos - {9'd0, fixed};
        prod = {17'd0, t} * 33'h0AAAB;
        comp = prod[32:17];
        rem = t - (comp + comp + comp);
        lsiz_exp = 18'd38 + {2'b00, v[15:0]} + {1'b0, v[15:0], 1'b0};
        pos1 = {1'b0, pos} + 17'd1;

        // Tile header bytes count toward Psot, saturating
        if ((ph == PH_SEG && seg_tile) || ph == PH_TILE0 || ph == PH_TILE1)
        begin
            if (tbs != 32'hFFFF_FFFF)
                tbs_next = tbs + 32'd1;
        end

        unique case (ph)
            PH_SEG:
            begin
                if (found)
                begin
                    vs_next = v;
                    if (f_last)
                    begin
                        res = '{fcode, v, 16'd0, seg_tile, ST_OK, 1'b0};
                        res_v = 1'b1;
                        if (fidx == 4'd0)
                        begin
                            len_next = v[15:0];
                            if (kd != SK_SIZ && v < {25'd0, fixed})
                            begin
                                err = 1'b1; err_st = ST_SHORT; err_val = v;
                            end
                        end
                        if (kd == SK_SIZ && fcode == FC_CSIZ)
                        begin
                            cc_next = v[15:0];
                            if ({2'b00, len} != lsiz_exp)
                            begin
                                err = 1'b1; err_st = ST_BAD_LSIZ; err_val = {16'd0, len};
                            end
                        end
                        if (fcode == FC_PSOT)
                        begin
                            tpl_next = v;
                            if (v == 32'd0)
                            begin
                                err = 1'b1; err_st = ST_SHORT; err_val = '0;
                            end
                        end
                    end
                end
                else if (kd == SK_SIZ)
                begin
                    res = '{FC_SSIZ + 6'(rem), {24'd0, b}, comp, seg_tile, ST_OK, 1'b0};
                    res_v = 1'b1;
                end
                else if (kd != SK_SOT)
                begin
                    res = '{seg_tail(kd), {24'd0, b}, t, seg_tile, ST_OK, 1'b0};
                    res_v = 1'b1;
                end
                err_tile = seg_tile;
                // Segment end after the last payload byte
                if (pos1 >= {10'd0, fixed} && pos1 == {1'b0, len_next})
                begin
                    phase_next = seg_tile ? PH_TILE0 : PH_MAIN0;
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos1[15:0];
                end
            end
            PH_SOC0:
            begin
                if (b != MK_FF) begin err = 1'b1; err_st = ST_NO_SOC; end
                else phase_next = PH_SOC1;
            end
            PH_SOC1:
            begin
                if (b != MK_SOC) begin err = 1'b1; err_st = ST_NO_SOC; end
                else phase_next = PH_SIZ0;
            end
            PH_SIZ0:
            begin
                if (b != MK_FF) begin err = 1'b1; err_st = ST_NO_SIZ; end
                else phase_next = PH_SIZ1;
            end
            PH_SIZ1:
            begin
                if (b != MK_SIZ) begin err = 1'b1; err_st = ST_NO_SIZ; end
                else begin phase_next = PH_SEG; kind_next = SK_SIZ; pos_next = '0;
                    len_next = '0; end
            end
            PH_MAIN0:
            begin
                if (b != MK_FF) begin err = 1'b1; err_st = ST_MAIN_FF; end
                else phase_next = PH_MAIN1;
            end
            PH_MAIN1:
            begin
                phase_next = PH_SEG; pos_next = '0; len_next = '0;
                priority if (b == MK_SOT)
                begin
                    kind_next = SK_SOT; tbs_next = 32'd2; tpl_next = '0;
                end
                else if (b == MK_COD) kind_next = SK_COD;
                else if (b == MK_QCD) kind_next = SK_QCD;
                else if (b == MK_QCC) kind_next = SK_QCCM;
                else if (b == MK_COM) kind_next = SK_COM;
                else begin err = 1'b1; err_st = ST_MAIN_MK; end
            end
            PH_TILE0:
            begin
                err_tile = 1'b1;
                if (b != MK_FF) begin err = 1'b1; err_st = ST_TILE_FF; end
                else phase_next = PH_TILE1;
            end
            PH_TILE1:
            begin
                err_tile = 1'b1;
                priority if (b == MK_SOD)
                begin
                    if (tpl < tbs_next)
                    begin
                        err = 1'b1; err_st = ST_SHORT; err_val = tpl;
                    end
                    else
                    begin
                        dbl_next = tpl - tbs_next;
                        pos_next = '0;
                        phase_next = (dbl_next != 32'd0) ? PH_DATA : PH_NEXT0;
                        res = '{FC_SOD, dbl_next, 16'd0, 1'b1, ST_OK, 1'b0};
                        res_v = 1'b1;
                    end
                end
                else if (b == MK_COC)
                begin
                    phase_next = PH_SEG; kind_next = SK_COC; pos_next = '0; len_next = '0;
                end
                else if (b == MK_QCC)
                begin
                    phase_next = PH_SEG; kind_next = SK_QCCT; pos_next = '0; len_next = '0;
                end
                else begin err = 1'b1; err_st = ST_TILE_MK; end
            end
            PH_DATA:
            begin
                res = '{FC_DATA, {24'd0, b}, pos, 1'b1, ST_OK, 1'b0};
                res_v = 1'b1;
                pos_next = pos + 16'd1;
                dbl_next = dbl - 32'd1;
                if (dbl_next == 32'd0)
                    phase_next = PH_NEXT0;
            end
            PH_NEXT0:
            begin
                if (b != MK_FF) begin err = 1'b1; err_st = ST_NEXT_FF; end
                else phase_next = PH_NEXT1;
            end
            PH_NEXT1:
            begin
                priority if (b == MK_EOC)
                begin
                    phase_next = PH_DONE;
                    res = '{FC_END, 32'h0000_FFD9, 16'd0, 1'b0, ST_OK, 1'b1};
                    res_v = 1'b1;
                end
                else if (b == MK_SOT)
                begin
                    phase_next = PH_SEG; kind_next = SK_SOT; pos_next = '0; len_next = '0;
                    tbs_next = 32'd2; tpl_next = '0;
                end
                else begin err = 1'b1; err_st = ST_NEXT_MK; end
            end
            default: ;
        endcase

        // Errors other than segment checks report the offending byte
        if (err)
        begin
            if (ph != PH_SEG && !(ph == PH_TILE1 && b == MK_SOD))
                err_val = {24'd0, b};
            phase_next = PH_DONE;
            res = '{FC_ERR, err_val, 16'd0, err_tile, err_st, 1'b1};
            res_v = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SOC0;
            kind_reg <= SK_SIZ;
            pos_reg <= '0;
            len_reg <= '0;
            vs_reg <= '0;
            cc_reg <= '0;
            tbs_reg <= '0;
            tpl_reg <= '0;
            dbl_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            kind_reg <= kind_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
            vs_reg <= vs_next;
            cc_reg <= cc_next;
            tbs_reg <= tbs_next;
            tpl_reg <= tpl_next;
            dbl_reg <= dbl_next;
        end
    end

    assign push.valid = take && res_v;
    assign push.item = res;

endmodule

// ===== rtl/cmp_fifo.sv =====
// Result queue between parser and output port; output read from the head entry.
// Depends on cmp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmp_fifo
    import cmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmp_push_t push,
    output logic      full,
    output logic      out_valid,
    input  logic      out_ready,
    output cmp_out_t  out_data
);

    cmp_out_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               pop;

    assign full = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign pop = out_valid && out_ready;
    assign out_data = mem[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg + (FIFO_AW+1)'(push.valid) - (FIFO_AW+1)'(pop);
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.item;
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            count_reg <= count_next;
        end
    end

    `ASSERT_IMP(a_no_push_full, full, !push.valid, "push into full result queue")
    `ASSERT_CLK(a_count_range, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count overflow")
    `ASSERT_IMP(a_ptr_match, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue pointers differ")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the codestream marker parser.
// Depends on cmp_pkg and codestream_marker_parser; it feeds generated codestreams and
// checks every result against an in-house model of the parser.
`timescale 1ns / 1ps

module tb;
    import cmp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // Parser phases of the checking model
    localparam int P_SIZ   = 0;
    localparam int P_COD   = 1;
    localparam int P_QCD   = 2;
    localparam int P_QCCM  = 3;
    localparam int P_COM   = 4;
    localparam int P_SOT   = 5;
    localparam int P_COC   = 6;
    localparam int P_QCCT  = 7;
    localparam int P_SOC0  = 8;
    localparam int P_SOC1  = 9;
    localparam int P_SIZ0  = 10;
    localparam int P_SIZ1  = 11;
    localparam int P_MAIN0 = 12;
    localparam int P_MAIN1 = 13;
    localparam int P_TILE0 = 14;
    localparam int P_TILE1 = 15;
    localparam int P_DATA  = 16;
    localparam int P_NEXT0 = 17;
    localparam int P_NEXT1 = 18;
    localparam int P_DONE  = 19;

    localparam int SZ_COMPNUM = 0;
    localparam int TAIL_TRIPLE = 255;
    localparam int TAIL_NONE   = 254;

    // Segment layout: field count, byte sizes, field codes, payload code
    int fld_count [8] = '{11, 10, 2, 3, 2, 5, 8, 3};
    int fld_size [8][11] = '{
        '{2, 2, 4, 4, 4, 4, 4, 4, 4, 4, 2},
        '{2, 1, 1, 2, 1, 1, 1, 1, 1, 1, 0},
        '{2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{2, SZ_COMPNUM, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{2, 2, 4, 1, 1, 0, 0, 0, 0, 0, 0},
        '{2, SZ_COMPNUM, 1, 1, 1, 1, 1, 1, 0, 0, 0},
        '{2, SZ_COMPNUM, 1, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    int fld_code [8][11] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10},
        '{14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 0},
        '{25, 26, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{28, 29, 30, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32, 33, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{35, 36, 37, 38, 39, 0, 0, 0, 0, 0, 0},
        '{40, 41, 42, 19, 20, 21, 22, 23, 0, 0, 0},
        '{28, 29, 30, 0, 0, 0, 0, 0, 0, 0, 0}
    };
    int payload_code [8] = '{TAIL_TRIPLE, 24, 27, 31, 34, TAIL_NONE, 24, 31};

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    cmp_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    cmp_out_t out_data;

    codestream_marker_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock and reset
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Model state
    int          pstate;
    logic [15:0] seg_pos;
    logic [15:0] seg_len;
    logic [31:0] shreg;
    logic [15:0] ncomp;
    logic [31:0] tile_bytes;
    logic [31:0] psot_len;
    logic [31:0] data_left;

    cmp_out_t expected_fields [$];
    cmp_in_t  stream_q [$];
    int       mismatches;
    int       bytes_sent;
    int       results_seen;
    int       error_results;
    int       streams_sent;
    int       burst_left;
    bit       hold_req;

    task automatic restart_model();
        pstate     = P_SOC0;
        seg_pos    = '0;
        seg_len    = '0;
        shreg      = '0;
        ncomp      = '0;
        tile_bytes = '0;
        psot_len   = '0;
        data_left  = '0;
    endtask

    task automatic raise_error(input logic [3:0] st, input logic [31:0] val, input bit tile,
                               output cmp_out_t r);
        pstate          = P_DONE;
        r               = '0;
        r.field_code    = FC_ERR;
        r.field_value   = val;
        r.in_tile       = tile;
        r.status        = st;
        r.last          = 1'b1;
    endtask

    task automatic enter_segment(input int ph);
        pstate  = ph;
        seg_pos = '0;
        seg_len = '0;
    endtask

    task automatic enter_tile_part();
        enter_segment(P_SOT);
        tile_bytes = 32'd2;
        psot_len   = '0;
    endtask

    // Expected result of one byte; got is 0 when the byte yields none
    task automatic parse_byte(input logic [7:0] b, input logic first, output bit got,
                              output cmp_out_t r);
        int unsigned pos, ncb, fixed, s, code, fidx, t, comp, v;
        bit found, fst, lst, tile;
        got   = 1'b0;
        r     = '0;
        found = 1'b0;
        fst   = 1'b0;
        lst   = 1'b0;
        code  = 0;
        fidx  = 0;
        if (first)
            restart_model();
        if ((pstate >= P_SOT && pstate <= P_QCCT) || pstate == P_TILE0 || pstate == P_TILE1)
        begin
            if (tile_bytes != 32'hFFFF_FFFF)
                tile_bytes = tile_bytes + 1;
        end
        if (pstate <= P_QCCT)
        begin
            // Segment byte: fixed field or payload
            tile  = (pstate >= P_SOT);
            pos   = 32'(seg_pos);
            ncb   = (ncomp < 16'd257) ? 1 : 2;
            fixed = 0;
            for (int i = 0; i < fld_count[pstate]; i++)
            begin
                s = fld_size[pstate][i];
                if (s == SZ_COMPNUM)
                    s = ncb;
                if (!found && pos >= fixed && pos < fixed + s)
                begin
                    found = 1'b1;
                    fst   = (pos == fixed);
                    lst   = (pos == fixed + s - 1);
                    code  = fld_code[pstate][i];
                    fidx  = i;
                end
                fixed += s;
            end
            if (found)
            begin
                shreg = fst ? {24'd0, b} : {shreg[23:0], b};
                if (lst)
                begin
                    v   = shreg;
                    got = 1'b1;
                    if (fidx == 0)
                    begin
                        seg_len = v[15:0];
                        if (pstate != P_SIZ && v < fixed)
                        begin
                            raise_error(ST_SHORT, v, tile, r);
                            return;
                        end
                    end
                    if (pstate == P_SIZ && code == FC_CSIZ)
                    begin
                        ncomp = v[15:0];
                        if (32'(seg_len) != 32'd38 + 32'd3 * v)
                        begin
                            raise_error(ST_BAD_LSIZ, {16'd0, seg_len}, tile, r);
                            return;
                        end
                    end
                    if (code == FC_PSOT)
                    begin
                        if (v == 0)
                        begin
                            raise_error(ST_SHORT, '0, tile, r);
                            return;
                        end
                        psot_len = v;
                    end
                    r.field_code  = code[5:0];
                    r.field_value = v;
                    r.in_tile     = tile;
                end
            end
            else
            begin
                t = pos - fixed;
                if (payload_code[pstate] == TAIL_TRIPLE)
                begin
                    comp            = t / 3;
                    got             = 1'b1;
                    r.field_code    = FC_SSIZ + 6'(t - 3 * comp);
                    r.field_value   = {24'd0, b};
                    r.element_index = comp[15:0];
                    r.in_tile       = tile;
                end
                else if (payload_code[pstate] != TAIL_NONE)
                begin
                    got             = 1'b1;
                    r.field_code    = 6'(payload_code[pstate]);
                    r.field_value   = {24'd0, b};
                    r.element_index = t[15:0];
                    r.in_tile       = tile;
                end
            end
            if (pos + 1 >= fixed && pos + 1 == 32'(seg_len))
            begin
                pstate  = tile ? P_TILE0 : P_MAIN0;
                seg_pos = '0;
            end
            else
                seg_pos = 16'(pos + 1);
            return;
        end
        case (pstate)
            P_SOC0:
                if (b != MK_FF)
                begin got = 1'b1; raise_error(ST_NO_SOC, {24'd0, b}, 1'b0, r); end
                else pstate = P_SOC1;
            P_SOC1:
                if (b != MK_SOC)
                begin got = 1'b1; raise_error(ST_NO_SOC, {24'd0, b}, 1'b0, r); end
                else pstate = P_SIZ0;
            P_SIZ0:
                if (b != MK_FF)
                begin got = 1'b1; raise_error(ST_NO_SIZ, {24'd0, b}, 1'b0, r); end
                else pstate = P_SIZ1;
            P_SIZ1:
                if (b != MK_SIZ)
                begin got = 1'b1; raise_error(ST_NO_SIZ, {24'd0, b}, 1'b0, r); end
                else enter_segment(P_SIZ);
            P_MAIN0:
                if (b != MK_FF)
                begin got = 1'b1; raise_error(ST_MAIN_FF, {24'd0, b}, 1'b0, r); end
                else pstate = P_MAIN1;
            P_MAIN1:
                if (b == MK_SOT) enter_tile_part();
                else if (b == MK_COD) enter_segment(P_COD);
                else if (b == MK_QCD) enter_segment(P_QCD);
                else if (b == MK_QCC) enter_segment(P_QCCM);
                else if (b == MK_COM) enter_segment(P_COM);
                else begin got = 1'b1; raise_error(ST_MAIN_MK, {24'd0, b}, 1'b0, r); end
            P_TILE0:
                if (b != MK_FF)
                begin got = 1'b1; raise_error(ST_TILE_FF, {24'd0, b}, 1'b1, r); end
                else pstate = P_TILE1;
            P_TILE1:
                if (b == MK_SOD)
                begin
                    // SOD: check Psot against the bytes already seen
                    got = 1'b1;
                    if (psot_len < tile_bytes)
                        raise_error(ST_SHORT, psot_len, 1'b1, r);
                    else
                    begin
                        data_left     = psot_len - tile_bytes;
                        seg_pos       = '0;
                        pstate        = (data_left != 0) ? P_DATA : P_NEXT0;
                        r.field_code  = FC_SOD;
                        r.field_value = data_left;
                        r.in_tile     = 1'b1;
                    end
                end
                else if (b == MK_COC) enter_segment(P_COC);
                else if (b == MK_QCC) enter_segment(P_QCCT);
                else begin got = 1'b1; raise_error(ST_TILE_MK, {24'd0, b}, 1'b1, r); end
            P_DATA:
            begin
                got             = 1'b1;
                r.field_code    = FC_DATA;
                r.field_value   = {24'd0, b};
                r.element_index = seg_pos;
                r.in_tile       = 1'b1;
                seg_pos         = seg_pos + 16'd1;
                data_left       = data_left - 1;
                if (data_left == 0)
                    pstate = P_NEXT0;
            end
            P_NEXT0:
                if (b != MK_FF)
                begin got = 1'b1; raise_error(ST_NEXT_FF, {24'd0, b}, 1'b0, r); end
                else pstate = P_NEXT1;
            P_NEXT1:
                if (b == MK_EOC)
                begin
                    got           = 1'b1;
                    pstate        = P_DONE;
                    r.field_code  = FC_END;
                    r.field_value = 32'h0000_FFD9;
                    r.last        = 1'b1;
                end
                else if (b == MK_SOT) enter_tile_part();
                else begin got = 1'b1; raise_error(ST_NEXT_MK, {24'd0, b}, 1'b0, r); end
            default: ;
        endcase
    endtask

    task automatic report(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        cmp_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_fields.size() == 0)
                report($sformatf("unexpected result code %0d", out_data.field_code));
            else
            begin
                e = expected_fields.pop_front();
                if (e.last) error_results++;
                if (out_data.field_code !== e.field_code)
                    report($sformatf("field_code %0d, want %0d", out_data.field_code,
                                     e.field_code));
                if (out_data.field_value !== e.field_value)
                    report($sformatf("field_value %h, want %h (code %0d)",
                                     out_data.field_value, e.field_value, e.field_code));
                if (out_data.element_index !== e.element_index)
                    report($sformatf("element_index %0d, want %0d (code %0d)",
                                     out_data.element_index, e.element_index, e.field_code));
                if (out_data.in_tile !== e.in_tile)
                    report($sformatf("in_tile %b, want %b (code %0d)", out_data.in_tile,
                                     e.in_tile, e.field_code));
                if (out_data.status !== e.status)
                    report($sformatf("status %0d, want %0d", out_data.status, e.status));
                if (out_data.last !== e.last)
                    report($sformatf("last %b, want %b (code %0d)", out_data.last, e.last,
                                     e.field_code));
            end
        end
    end

    // Receiver: stall pattern in phases, plus a long hold-off on request
    int  stall_pct;
    int  phase_left;
    int  hold_left;
    bit  hold_seen;
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (phase_left == 0)
        begin
            phase_left = $urandom_range(16, 120);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
        end
        else
            phase_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Run limit
    int cycles;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one byte; called right after a rising edge
    task automatic send_byte(input cmp_in_t x);
        bit       got;
        cmp_out_t r;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                      : $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= x;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        bytes_sent++;
        parse_byte(x.code_byte, x.first_byte, got, r);
        if (got)
            expected_fields.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] b, input bit first = 1'b0);
        cmp_in_t x;
        x.code_byte  = b;
        x.first_byte = first;
        stream_q.push_back(x);
    endtask

    // Marker segment with a length that is usually valid
    task automatic add_segment(input logic [7:0] mk, input int fixed);
        int len;
        if ($urandom_range(0, 19) == 0)
            len = $urandom_range(0, fixed - 1);
        else
            len = fixed + $urandom_range(0, 4);
        add_byte(MK_FF);
        add_byte(mk);
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        for (int i = 2; i < len; i++)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    // One codestream, mostly well formed, with random content
    task automatic build_stream(input int comps);
        int ncb, start, len, nd, psot, tiles, pick, extra;
        stream_q.delete();
        ncb = (comps < 257) ? 1 : 2;
        add_byte(MK_FF, 1'b1);
        add_byte(MK_SOC);
        add_byte(MK_FF);
        add_byte(MK_SIZ);
        len = 38 + 3 * comps;
        if ($urandom_range(0, 14) == 0)
            len = len + $urandom_range(0, 1) * 2 - 1;
        add_byte(len[15:8]);
        add_byte(len[7:0]);
        for (int i = 0; i < 34; i++)
            add_byte(8'($urandom_range(0, 255)));
        add_byte(comps[15:8]);
        add_byte(comps[7:0]);
        for (int i = 0; i < 3 * comps; i++)
            add_byte(8'($urandom_range(0, 255)));
        // Main header segments
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 3))
                0: add_segment(MK_COD, 12);
                1: add_segment(MK_QCD, 3);
                2: add_segment(MK_QCC, 2 + ncb + 1);
                default: add_segment(MK_COM, 4);
            endcase
        end
        tiles = $urandom_range(1, 3);
        for (int tp = 0; tp < tiles; tp++)
        begin
            start = stream_q.size();
            extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            len   = 10 + extra;
            if ($urandom_range(0, 24) == 0)
                len = $urandom_range(0, 9);
            add_byte(MK_FF);
            add_byte(MK_SOT);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
            for (int i = 2; i < len; i++)
                add_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2))
            begin
                if ($urandom_range(0, 1) != 0) add_segment(MK_COC, 7 + ncb);
                else add_segment(MK_QCC, 2 + ncb + 1);
            end
            add_byte(MK_FF);
            add_byte(MK_SOD);
            nd   = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            psot = stream_q.size() - start + nd;
            pick = $urandom_range(0, 19);
            if (pick == 0) psot = 0;
            else if (pick == 1) psot = $urandom_range(1, stream_q.size() - start - 1);
            else if (pick == 2) psot = $urandom();
            // Psot sits after marker, Lsot and Isot
            if (len >= 10)
                for (int k = 0; k < 4; k++)
                    stream_q[start + 6 + k].code_byte = 8'(psot >> (8 * (3 - k)));
            for (int i = 0; i < nd; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
        add_byte(MK_FF);
        add_byte(MK_EOC);
        // Occasional damage: a random byte, a restart mid-stream, trailing junk
        pick = $urandom_range(0, 9);
        if (pick == 0)
            stream_q[$urandom_range(1, stream_q.size() - 1)].code_byte =
                8'($urandom_range(0, 255));
        else if (pick == 1)
            stream_q[$urandom_range(1, stream_q.size() - 1)].first_byte = 1'b1;
        if ($urandom_range(0, 3) == 0)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_stream();
        streams_sent++;
        foreach (stream_q[i])
            send_byte(stream_q[i]);
    endtask

    // Start markers wrong, and bytes after an error ignored
    task automatic test_bad_start();
        stream_q.delete();
        add_byte(8'h00, 1'b1);
        add_byte(8'hAA);
        add_byte(MK_FF, 1'b1);
        add_byte(8'hFE);
        add_byte(MK_FF, 1'b1);
        add_byte(MK_SOC);
        add_byte(8'h7F);
        add_byte(MK_FF, 1'b1);
        add_byte(MK_SOC);
        add_byte(MK_FF);
        add_byte(MK_COD);
        add_byte(MK_FF);
        add_byte(8'h00, 1'b1);
        send_stream();
    endtask

    // Random codestreams, a few of pure noise
    task automatic test_random_streams(input int target);
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                stream_q.delete();
                add_byte(8'($urandom_range(0, 255)), 1'b1);
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
            end
            else
                build_stream(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                          : $urandom_range(1, 4));
            send_stream();
        end
    endtask

    // Two-byte component numbers
    task automatic test_wide_components();
        build_stream(257);
        send_stream();
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        hold_req <= ~hold_req;
        burst_left = 200;
        build_stream(2);
        send_stream();
    endtask

    initial
    begin
        mismatches = 0;
        hold_req   = 1'b0;
        burst_left = 0;
        restart_model();
        @(posedge rst_n);
        @(posedge clk);
        test_bad_start();
        test_random_streams(60);
        test_wide_components();
        test_backpressure();
        in_valid <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("ran %0d codestreams, %0d bytes, %0d results (%0d ends or errors)",
                 streams_sent, bytes_sent, results_seen, error_results);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
